// ----- rtl/tdts_pkg.sv -----
// Shared types and codes for the timed dispense test sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tdts_pkg;

	localparam int unsigned CfgIndexW = 3;

	// action codes of the input word
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	// dispense command codes
	localparam logic [1:0] DISP_NONE = 2'd0;
	localparam logic [1:0] DISP_COLD = 2'd1;
	localparam logic [1:0] DISP_ROOM = 2'd2;
	localparam logic [1:0] DISP_HOT  = 2'd3;

	// configuration register indexes
	localparam logic [CfgIndexW-1:0] REG_PAUSE_TICKS     = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_DOOR_OPEN_TICKS = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_LIMIT_TICKS     = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_HOT_MIN_TEMP    = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_COLD_MAX_TEMP   = 3'd4;

	// register reset values
	localparam logic [15:0]        PAUSE_TICKS_RST     = 16'd6000;
	localparam logic [15:0]        DOOR_OPEN_TICKS_RST = 16'd200;
	localparam logic [15:0]        LIMIT_TICKS_RST     = 16'd3000;
	localparam logic signed [11:0] HOT_MIN_TEMP_RST    = 12'sd700;
	localparam logic signed [11:0] COLD_MAX_TEMP_RST   = 12'sd100;

	// cycle counter saturates at 1999: tens 199, ones 9
	localparam logic [7:0] CYCLE_TENS_MAX = 8'd199;
	localparam logic [3:0] CYCLE_ONES_MAX = 4'd9;

	typedef struct packed {
		logic [1:0]        action;
		logic              dispense_busy;
		logic              room_tank_full;
		logic              cold_tank_full;
		logic signed [11:0] hot_temp;
		logic signed [11:0] cold_temp;
	} in_t;

	typedef struct packed {
		logic [1:0] dispense_cmd;
		logic       release_continue;
		logic       door_open_cmd;
		logic       door_close_cmd;
		logic       beep;
		logic [7:0] cycles_done;
		logic       limit_expired;
		logic       test_active;
		logic [3:0] step_now;
	} out_t;

	typedef struct packed {
		logic [15:0]        pause_ticks;
		logic [15:0]        door_open_ticks;
		logic signed [11:0] hot_min_temp;
		logic signed [11:0] cold_max_temp;
	} cfg_t;

	// load request for the limit countdown, raised by a limit_ticks write
	typedef struct packed {
		logic        load;
		logic [15:0] value;
	} lim_load_t;

endpackage

`default_nettype wire

// ----- rtl/tdts_cfg.sv -----
// Configuration register file of the timed dispense test sequencer.
// Depends on tdts_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module tdts_cfg import tdts_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CfgIndexW-1:0] wr_index,
	input  wire logic [15:0]          wr_data,
	output cfg_t                      cfg,
	output lim_load_t                 lim
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pause_ticks     <= PAUSE_TICKS_RST;
			cfg_q.door_open_ticks <= DOOR_OPEN_TICKS_RST;
			cfg_q.hot_min_temp    <= HOT_MIN_TEMP_RST;
			cfg_q.cold_max_temp   <= COLD_MAX_TEMP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PAUSE_TICKS:     cfg_q.pause_ticks     <= wr_data;
				REG_DOOR_OPEN_TICKS: cfg_q.door_open_ticks <= wr_data;
				REG_HOT_MIN_TEMP:    cfg_q.hot_min_temp    <= $signed(wr_data[11:0]);
				REG_COLD_MAX_TEMP:   cfg_q.cold_max_temp   <= $signed(wr_data[11:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// limit_ticks lives only as the countdown's load value
	assign lim.load  = wr_en && (wr_index == REG_LIMIT_TICKS);
	assign lim.value = wr_data;

endmodule

`default_nettype wire

// ----- rtl/tdts_core.sv -----
// Sequencer state and per-word step logic: timers, step, cycle count.
// Depends on tdts_pkg; fed by tdts_cfg, result goes to tdts_skid.
`timescale 1ns / 1ps
`default_nettype none

module tdts_core import tdts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_fire,
	input  in_t        in_word,
	input  cfg_t       cfg,
	input  lim_load_t  lim,
	output out_t       result
);

	localparam logic [3:0] ST_INIT       = 4'd0;
	localparam logic [3:0] ST_COLD_START = 4'd1;
	localparam logic [3:0] ST_COLD_WAIT  = 4'd2;
	localparam logic [3:0] ST_COLD_PAUSE = 4'd3;
	localparam logic [3:0] ST_ROOM_START = 4'd4;
	localparam logic [3:0] ST_ROOM_WAIT  = 4'd5;
	localparam logic [3:0] ST_ROOM_PAUSE = 4'd6;
	localparam logic [3:0] ST_HOT_START  = 4'd7;
	localparam logic [3:0] ST_HOT_WAIT   = 4'd8;
	localparam logic [3:0] ST_HOT_PAUSE  = 4'd9;
	localparam logic [3:0] ST_DOOR_OPEN  = 4'd10;
	localparam logic [3:0] ST_DOOR_WAIT  = 4'd11;
	localparam logic [3:0] ST_END_PAUSE  = 4'd12;

	logic        enabled_q, enabled_d;
	logic [3:0]  step_q, step_d;
	logic [15:0] pause_q, pause_d;
	logic [15:0] limit_q, limit_d;
	logic [15:0] door_q, door_d;
	// cycle total kept as tens and ones so the divide by ten is free
	logic [7:0]  tens_q, tens_d;
	logic [3:0]  ones_q, ones_d;

	logic hold;

	always_comb begin
		enabled_d = enabled_q;
		step_d    = step_q;
		pause_d   = pause_q;
		limit_d   = limit_q;
		door_d    = door_q;
		tens_d    = tens_q;
		ones_d    = ones_q;

		result.dispense_cmd     = DISP_NONE;
		result.release_continue = 1'b0;
		result.door_open_cmd    = 1'b0;
		result.door_close_cmd   = 1'b0;
		result.beep             = 1'b0;

		hold = !in_word.room_tank_full || !in_word.cold_tank_full
			|| ($signed(in_word.hot_temp) <= $signed(cfg.hot_min_temp))
			|| ($signed(in_word.cold_temp) >= $signed(cfg.cold_max_temp));

		unique case (in_word.action)
			ACT_START: enabled_d = 1'b1;
			ACT_STOP:  enabled_d = 1'b0;
			ACT_TICK: begin
				if (limit_q != 16'd0)
					limit_d = limit_q - 16'd1;
				if (enabled_q) begin
					if (hold) begin
						pause_d = cfg.pause_ticks;
					end else begin
						unique case (step_q)
							ST_INIT: step_d = ST_COLD_START;
							ST_COLD_START, ST_ROOM_START, ST_HOT_START: begin
								priority if (step_q == ST_COLD_START)
									result.dispense_cmd = DISP_COLD;
								else if (step_q == ST_ROOM_START)
									result.dispense_cmd = DISP_ROOM;
								else
									result.dispense_cmd = DISP_HOT;
								result.beep = 1'b1;
								step_d = step_q + 4'd1;
							end
							ST_COLD_WAIT, ST_ROOM_WAIT, ST_HOT_WAIT: begin
								if (!in_word.dispense_busy) begin
									result.release_continue = 1'b1;
									pause_d = cfg.pause_ticks;
									step_d  = step_q + 4'd1;
								end
							end
							ST_COLD_PAUSE, ST_ROOM_PAUSE, ST_HOT_PAUSE: begin
								if (pause_q != 16'd0)
									pause_d = pause_q - 16'd1;
								else
									step_d = step_q + 4'd1;
							end
							ST_DOOR_OPEN: begin
								result.door_open_cmd = 1'b1;
								result.beep          = 1'b1;
								step_d               = ST_DOOR_WAIT;
							end
							ST_DOOR_WAIT: begin
								if (door_q < cfg.door_open_ticks) begin
									door_d = door_q + 16'd1;
								end else begin
									// count a cycle, saturate at the top
									if (!(tens_q == CYCLE_TENS_MAX && ones_q == CYCLE_ONES_MAX)) begin
										if (ones_q == CYCLE_ONES_MAX) begin
											ones_d = 4'd0;
											tens_d = tens_q + 8'd1;
										end else begin
											ones_d = ones_q + 4'd1;
										end
									end
									result.door_close_cmd = 1'b1;
									door_d  = 16'd0;
									pause_d = cfg.pause_ticks;
									step_d  = ST_END_PAUSE;
								end
							end
							ST_END_PAUSE: begin
								if (pause_q != 16'd0)
									pause_d = pause_q - 16'd1;
								else
									step_d = ST_INIT;
							end
							default: step_d = ST_INIT;
						endcase
					end
				end
			end
			default: ;
		endcase

		if (lim.load)
			limit_d = lim.value;

		result.cycles_done   = tens_d;
		result.limit_expired = (limit_d == 16'd0);
		result.test_active   = enabled_d;
		result.step_now      = step_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			step_q    <= ST_INIT;
			pause_q   <= 16'd0;
			limit_q   <= LIMIT_TICKS_RST;
			door_q    <= 16'd0;
			tens_q    <= 8'd0;
			ones_q    <= 4'd0;
		end else if (in_fire) begin
			enabled_q <= enabled_d;
			step_q    <= step_d;
			pause_q   <= pause_d;
			limit_q   <= limit_d;
			door_q    <= door_d;
			tens_q    <= tens_d;
			ones_q    <= ones_d;
		end else if (lim.load) begin
			limit_q <= lim.value;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tdts_skid.sv -----
// Result register with a skid entry, so input never waits on output stall
// combinationally. Depends on tdts_pkg for out_t.
`timescale 1ns / 1ps
`default_nettype none

module tdts_skid import tdts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  out_t      push_word,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_word
);

	logic main_valid_q, skid_valid_q;
	out_t main_q, skid_q;
	logic pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q || pop)
				main_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_valid_q || pop)
				main_q <= push_word;
			else
				skid_q <= push_word;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;

endmodule

`default_nettype wire

// ----- rtl/timed_dispense_test_sequencer_unit.sv -----
// Top level of the timed dispense test sequencer.
// Depends on tdts_pkg, tdts_cfg, tdts_core and tdts_skid.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one word per tick
//   (100 ms), start or stop event. A word is taken on a rising edge with
//   in_valid high and in_stall low.
//   Output channel out_valid / out_stall / out_data returns exactly one
//   result word per input word, in order.
//   Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data
//   writes the five registers; cfg_ready is always high. Write only while
//   no result is outstanding. Writing limit_ticks also reloads the limit
//   countdown.
//   A result is registered into the result register, or the skid entry if
//   that one is stalled. Throughput: one word per cycle while in_stall is low,
//   set by the single step of state logic from state to result register.
//   Stall: a result register plus one skid entry hold results; in_stall
//   rises only once both are occupied and is driven from a register.
//   Reset: arst_n clears the sequencer to disabled, step 0, timers zero,
//   limit countdown 3000 and registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module timed_dispense_test_sequencer_unit import tdts_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  in_t                       in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_t                      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	cfg_t      cfg;
	lim_load_t lim;
	out_t      result;
	logic      in_fire;
	logic      skid_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_full;
	assign in_fire   = in_valid && !skid_full;

	tdts_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.lim      (lim)
	);

	tdts_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_word (in_data),
		.cfg     (cfg),
		.lim     (lim),
		.result  (result)
	);

	tdts_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_word (result),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_data)
	);

endmodule

`default_nettype wire

// ----- rtl/tdts_chk.sv -----
// Port-level checker for the timed dispense test sequencer, bound to the top.
// Depends on tdts_pkg and timed_dispense_test_sequencer_unit.
`timescale 1ns / 1ps
`default_nettype none

module tdts_chk import tdts_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input out_t      out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.step_now <= 4'd12)
		else $error("step out of range");

	a_cycles_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cycles_done <= CYCLE_TENS_MAX)
		else $error("cycle count past saturation");

	// commands only come from an enabled sequencer
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.test_active |->
			out_data.dispense_cmd == DISP_NONE && !out_data.release_continue
			&& !out_data.door_open_cmd && !out_data.door_close_cmd && !out_data.beep)
		else $error("command issued while disabled");

endmodule

bind timed_dispense_test_sequencer_unit tdts_chk u_tdts_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for timed_dispense_test_sequencer_unit: status words are checked against a
// predictor kept in step with every accepted input word and register write.
// Depends on tdts_pkg and the RTL of the sequencer; needs nothing else.
`timescale 1ns / 1ps

module tb;
	import tdts_pkg::*;

	localparam int CycleCap = 1999;
	localparam int StuckLimit = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state and register copies
	logic tst_on;
	logic [3:0] seq_step;
	logic [15:0] pause_cnt, limit_cnt, door_cnt;
	logic [10:0] cycle_cnt;
	logic [15:0] pause_len, door_len, limit_len;
	logic signed [11:0] hot_min, cold_max;

	out_t status_due [$];
	int fails = 0;
	int stuck_cycles = 0;
	logic quiet = 1'b0;

	timed_dispense_test_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 17);
	end

	function automatic void reset_sequencer_model();
		pause_len = PAUSE_TICKS_RST;
		door_len = DOOR_OPEN_TICKS_RST;
		limit_len = LIMIT_TICKS_RST;
		hot_min = HOT_MIN_TEMP_RST;
		cold_max = COLD_MAX_TEMP_RST;
		tst_on = 1'b0;
		seq_step = 4'd0;
		pause_cnt = '0;
		limit_cnt = limit_len;
		cycle_cnt = '0;
		door_cnt = '0;
	endfunction

	function automatic out_t sequencer_step(in_t w);
		out_t r;
		logic held;
		r = '0;
		case (w.action)
			ACT_START: tst_on = 1'b1;
			ACT_STOP: tst_on = 1'b0;
			ACT_TICK: begin
				if (limit_cnt != 0)
					limit_cnt = limit_cnt - 1'b1;
				if (tst_on) begin
					held = !w.room_tank_full || !w.cold_tank_full ||
						($signed(w.hot_temp) <= $signed(hot_min)) ||
						($signed(w.cold_temp) >= $signed(cold_max));
					if (held) begin
						pause_cnt = pause_len;
					end else begin
						case (seq_step)
							4'd0: seq_step = 4'd1;
							4'd1, 4'd4, 4'd7: begin
								r.dispense_cmd = (seq_step == 4'd1) ? DISP_COLD :
									(seq_step == 4'd4) ? DISP_ROOM : DISP_HOT;
								r.beep = 1'b1;
								seq_step = seq_step + 1'b1;
							end
							4'd2, 4'd5, 4'd8: begin
								if (!w.dispense_busy) begin
									r.release_continue = 1'b1;
									pause_cnt = pause_len;
									seq_step = seq_step + 1'b1;
								end
							end
							4'd3, 4'd6, 4'd9: begin
								if (pause_cnt != 0)
									pause_cnt = pause_cnt - 1'b1;
								else
									seq_step = seq_step + 1'b1;
							end
							4'd10: begin
								r.door_open_cmd = 1'b1;
								r.beep = 1'b1;
								seq_step = 4'd11;
							end
							4'd11: begin
								if (door_cnt < door_len) begin
									door_cnt = door_cnt + 1'b1;
								end else begin
									if (cycle_cnt < CycleCap)
										cycle_cnt = cycle_cnt + 1'b1;
									r.door_close_cmd = 1'b1;
									door_cnt = '0;
									pause_cnt = pause_len;
									seq_step = 4'd12;
								end
							end
							4'd12: begin
								if (pause_cnt != 0)
									pause_cnt = pause_cnt - 1'b1;
								else
									seq_step = 4'd0;
							end
							default: seq_step = 4'd0;
						endcase
					end
				end
			end
			default: ;
		endcase
		r.cycles_done = 8'(cycle_cnt / 10);
		r.limit_expired = (limit_cnt == 0);
		r.test_active = tst_on;
		r.step_now = seq_step;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PAUSE_TICKS: pause_len = cfg_data;
					REG_DOOR_OPEN_TICKS: door_len = cfg_data;
					REG_LIMIT_TICKS: begin
						limit_len = cfg_data;
						limit_cnt = cfg_data;
					end
					REG_HOT_MIN_TEMP: hot_min = cfg_data[11:0];
					REG_COLD_MAX_TEMP: cold_max = cfg_data[11:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				status_due.push_back(sequencer_step(in_data));
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$error("status word with none outstanding");
					fails++;
				end else begin
					want = status_due.pop_front();
					check_field("dispense_cmd", want.dispense_cmd, out_data.dispense_cmd);
					check_field("release_continue", want.release_continue,
						out_data.release_continue);
					check_field("door_open_cmd", want.door_open_cmd, out_data.door_open_cmd);
					check_field("door_close_cmd", want.door_close_cmd, out_data.door_close_cmd);
					check_field("beep", want.beep, out_data.beep);
					check_field("cycles_done", want.cycles_done, out_data.cycles_done);
					check_field("limit_expired", want.limit_expired, out_data.limit_expired);
					check_field("test_active", want.test_active, out_data.test_active);
					check_field("step_now", want.step_now, out_data.step_now);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= StuckLimit) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// entered and left at a falling edge; valid stays high for a following word
	task automatic send_word(input in_t w);
		if (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and wait out every outstanding status word
	task automatic drain();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic load_regs(input logic [15:0] p, input logic [15:0] d, input logic [15:0] l,
		input logic signed [11:0] h, input logic signed [11:0] c);
		logic [CfgIndexW-1:0] idx [5];
		logic [15:0] val [5];
		idx = '{REG_PAUSE_TICKS, REG_DOOR_OPEN_TICKS, REG_LIMIT_TICKS,
			REG_HOT_MIN_TEMP, REG_COLD_MAX_TEMP};
		val = '{p, d, l, {{4{h[11]}}, h}, {{4{c[11]}}, c}};
		for (int i = 0; i < 5; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic in_t sensor_word(input logic [1:0] act, input logic busy,
		input logic room, input logic coldf, input int hot, input int cold);
		in_t w;
		w.action = act;
		w.dispense_busy = busy;
		w.room_tank_full = room;
		w.cold_tank_full = coldf;
		w.hot_temp = 12'(hot);
		w.cold_temp = 12'(cold);
		return w;
	endfunction

	// mostly ticks that let the sequence advance, the rest holds, events and noise
	function automatic in_t pick_sensor_word();
		in_t w;
		int unsigned r;
		int hm, cm;
		hm = hot_min;
		cm = cold_max;
		r = $urandom_range(99);
		w.action = (r < 4) ? ACT_START : (r < 6) ? ACT_STOP : (r < 7) ? 2'd3 : ACT_TICK;
		w.dispense_busy = ($urandom_range(99) < 35);
		if (hm < 1500 && cm > -400 && $urandom_range(99) >= 8) begin
			w.room_tank_full = 1'b1;
			w.cold_tank_full = 1'b1;
			w.hot_temp = 12'(hm + 1 + int'($urandom_range(1499 - hm)));
			w.cold_temp = 12'(-400 + int'($urandom_range(cm - 1 + 400)));
		end else begin
			w.room_tank_full = ($urandom_range(99) < 70);
			w.cold_tank_full = ($urandom_range(99) < 70);
			w.hot_temp = 12'(int'($urandom_range(1900)) - 400);
			w.cold_temp = 12'(int'($urandom_range(1900)) - 400);
		end
		return w;
	endfunction

	task automatic test_directed_cases();
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 800, 50));
		send_word(sensor_word(2'd3, 1'b1, 1'b0, 1'b0, -400, 1500));
		send_word(sensor_word(ACT_START, 1'b0, 1'b1, 1'b1, 800, 50));
		// each hold condition alone, temperatures right at the limits
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b0, 1'b1, 800, 50));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b0, 800, 50));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 700, 50));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 800, 100));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, -400, 50));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 800, 1500));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 701, 99));
		send_word(sensor_word(ACT_TICK, 1'b1, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_TICK, 1'b1, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_STOP, 1'b0, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_START, 1'b1, 1'b0, 1'b0, 0, 0));
		send_word(sensor_word(ACT_TICK, 1'b0, 1'b1, 1'b1, 0, 0));
		send_word(sensor_word(ACT_START, 1'b0, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_STOP, 1'b0, 1'b1, 1'b1, 1500, -400));
		send_word(sensor_word(ACT_STOP, 1'b1, 1'b1, 1'b1, 1500, -400));
		drain();
	endtask

	task automatic test_register_extremes();
		// zero limit expires at once; widest window for the temperatures
		load_regs(16'd0, 16'd0, 16'd0, -12'sd400, 12'sd1500);
		send_word(sensor_word(ACT_START, 1'b0, 1'b1, 1'b1, 0, 0));
		repeat (40) send_word(pick_sensor_word());
		drain();
		// every tick held: no temperature is both hot and cold enough
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'sd1500, -12'sd400);
		send_word(sensor_word(ACT_START, 1'b0, 1'b1, 1'b1, 0, 0));
		repeat (15) send_word(pick_sensor_word());
		drain();
	endtask

	task automatic test_random_sequences();
		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 2);
			load_regs(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(300)),
				12'(int'($urandom_range(1800)) - 400), 12'(int'($urandom_range(1800)) - 300));
			send_word(sensor_word(ACT_START, 1'b0, 1'b1, 1'b1, 0, 0));
			repeat (110) send_word(pick_sensor_word());
			drain();
		end
		quiet = 1'b0;
	endtask

	// run a few full cycles at the shortest timings, never held
	task automatic test_full_cycles();
		load_regs(16'd0, 16'd0, 16'd100, HOT_MIN_TEMP_RST, COLD_MAX_TEMP_RST);
		send_word(sensor_word(ACT_START, 1'b0, 1'b1, 1'b1, 0, 0));
		repeat (30)
			send_word(sensor_word(ACT_TICK, ($urandom_range(99) < 25), 1'b1, 1'b1, 1500, -400));
		drain();
	endtask

	initial begin
		reset_sequencer_model();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_register_extremes();
		test_random_sequences();
		test_full_cycles();
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
